[design/kdee_pkg.sv]
// shared types and constants for the key debounce event engine
`default_nettype none
package kdee_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_POP   = 2'd1,
    OP_COUNT = 2'd2,
    OP_INIT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_DOWN   = 3'd0,
    KIND_UP     = 3'd1,
    KIND_CLICK  = 3'd2,
    KIND_LONG   = 3'd3,
    KIND_REPEAT = 3'd4,
    KIND_CW     = 3'd5,
    KIND_CCW    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_LONG      = 3'd1,
    REG_REP_START = 3'd2,
    REG_REP_PER   = 3'd3,
    REG_ACT_HIGH  = 3'd4
  } reg_e;

  localparam logic [2:0] LockKey = 3'd5;

  // one decoded op handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [15:0] keys;
    logic [1:0]  enc;
  } cmd_t;

  // quadrature step: -1, 0, +1 as 2-bit signed
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

[design/kdee_front.sv]
// front end: command capture and pin polarity, small queue toward the back end
`default_nettype none
module kdee_front #(
  parameter int NUM_KEYS = 8
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire  [1:0]        op_i,
  input  wire  [31:0]       now_time_i,
  input  wire  [7:0]        key_pins_i,
  input  wire               enc_a_pin_i,
  input  wire               enc_b_pin_i,
  input  wire               active_high_i,
  input  wire               pop_i,
  output logic              busy_o,
  output logic              cmd_valid_o,
  output kdee_pkg::cmd_t    cmd_o
);
  // two-entry queue, but only one op in flight (one result per op)
  kdee_pkg::cmd_t q_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           inflight_q;
  logic           acc;
  kdee_pkg::cmd_t c;
  logic [15:0]    kp;
  integer         k;

  always_comb begin
    kp = '0;
    for (k = 0; k < 16; k++) begin
      kp[k] = (key_pins_i[k & 7] == active_high_i);
    end
    c.op   = op_i;
    c.now  = now_time_i;
    c.keys = kp;
    c.enc  = {enc_a_pin_i == active_high_i, enc_b_pin_i == active_high_i};
  end

  assign busy_o      = inflight_q;
  assign acc         = start_i && !inflight_q;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
      inflight_q <= 1'b0;
    end else begin
      if (acc) begin
        wp_q <= ~wp_q;
        inflight_q <= 1'b1;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop_i};
      if (pop_i) inflight_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) q_q[wp_q] <= c;
  end
endmodule
`default_nettype wire

[design/kdee_back.sv]
// back end: walks keys one per cycle (pausing for events), then encoder; owns event queue
`default_nettype none
module kdee_back #(
  parameter int NUM_KEYS     = 8,
  parameter int QUEUE_DEPTH  = 32,
  parameter int DETENT_STEPS = 4
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cmd_valid_i,
  input  kdee_pkg::cmd_t  cmd_i,
  input  wire  [15:0]     debounce_time_i,
  input  wire  [15:0]     long_press_time_i,
  input  wire  [15:0]     repeat_start_time_i,
  input  wire  [15:0]     repeat_period_i,
  output logic            cmd_pop_o,
  output logic            done_o,
  output logic            event_valid_o,
  output logic [2:0]      event_kind_o,
  output logic [2:0]      event_key_o,
  output logic [1:0]      event_amount_o,
  output logic [7:0]      pressed_mask_o,
  output logic [15:0]     encoder_count_o,
  output logic [4:0]      queue_fill_o
);
  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH);
  // detent thresholds as signed step counts
  localparam logic signed [3:0] DetentPos = 4'(DETENT_STEPS);
  localparam logic signed [3:0] DetentNeg = -DetentPos;

  typedef enum logic [2:0] {
    S_IDLE, S_KEY, S_EV, S_ENC, S_ENCEV, S_RD, S_DONE
  } state_e;

  state_e             st_q;
  logic [KW-1:0]      k_q;
  logic [NUM_KEYS-1:0] raw_q, stb_q, ld_q;
  logic [31:0]        chg_q [NUM_KEYS];
  logic [31:0]        prs_q [NUM_KEYS];
  logic [31:0]        rpt_q [NUM_KEYS];
  logic [7:0]         mem [QUEUE_DEPTH];
  logic [7:0]         rd_q;
  logic [QW-1:0]      wi_q, ri_q;
  logic [1:0]         encp_q;
  logic signed [3:0]  steps_q;
  logic [15:0]        net_q;
  // pending events for current key: down/up, click, long, repeat
  logic [3:0]         pend_q;
  logic [2:0]         evk_q;

  // per-key combinational evaluation
  logic        r, rawn, stbn, ldn, fire, up, lng, rep;
  logic [31:0] chgn, prsn, held;
  logic [3:0]  pend;
  logic [QW-1:0] wn, rn;
  logic        full;
  logic signed [3:0] sn;
  logic [1:0]  ev_pick;
  logic [2:0]  ev_kind;
  logic [QW:0] fill;

  assign r    = cmd_i.keys[k_q];
  assign rawn = r;
  assign chgn = (r != raw_q[k_q]) ? cmd_i.now : chg_q[k_q];
  assign fire = (stb_q[k_q] != rawn) && ((cmd_i.now - chgn) >= {16'd0, debounce_time_i});
  assign stbn = fire ? rawn : stb_q[k_q];
  assign up   = fire && !rawn;
  assign prsn = (fire && rawn) ? cmd_i.now : prs_q[k_q];
  assign held = cmd_i.now - prsn;
  assign lng  = stbn && !(ld_q[k_q] && !(fire && rawn)) && (held >= {16'd0, long_press_time_i});
  assign rep  = stbn && (repeat_start_time_i != 16'd0) && (held >= {16'd0, repeat_start_time_i})
                && ((cmd_i.now - ((fire && rawn) ? cmd_i.now : rpt_q[k_q]))
                    >= {16'd0, repeat_period_i});
  assign ldn  = (fire && rawn) ? lng : (ld_q[k_q] | lng);
  assign pend = {rep, lng, up && !ld_q[k_q], fire};

  assign wn   = (wi_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wi_q + 1'b1;
  assign rn   = (ri_q == QW'(QUEUE_DEPTH - 1)) ? '0 : ri_q + 1'b1;
  assign full = (wn == ri_q);

  // lowest pending event first
  always_comb begin
    ev_pick = 2'd0;
    ev_kind = kdee_pkg::KIND_DOWN;
    if (pend_q[0]) begin
      ev_pick = 2'd0;
      ev_kind = stb_q[k_q] ? kdee_pkg::KIND_DOWN : kdee_pkg::KIND_UP;
    end else if (pend_q[1]) begin
      ev_pick = 2'd1; ev_kind = kdee_pkg::KIND_CLICK;
    end else if (pend_q[2]) begin
      ev_pick = 2'd2; ev_kind = kdee_pkg::KIND_LONG;
    end else begin
      ev_pick = 2'd3; ev_kind = kdee_pkg::KIND_REPEAT;
    end
  end

  assign sn = steps_q + 4'(kdee_pkg::quad_step({encp_q, cmd_i.enc}));

  assign fill = (wi_q >= ri_q) ? {1'b0, wi_q - ri_q}
                               : (QW+1)'(QUEUE_DEPTH) - {1'b0, ri_q} + {1'b0, wi_q};

  always_comb begin
    pressed_mask_o = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < NUM_KEYS) pressed_mask_o[i] = stb_q[i];
    end
  end
  assign queue_fill_o = 5'(fill);
  assign done_o       = (st_q == S_DONE);
  assign cmd_pop_o    = (st_q == S_DONE);

  always_ff @(posedge clk_i) begin
    if (st_q == S_EV && !full) begin
      mem[wi_q] <= {2'b00, 3'(k_q), ev_kind};
    end else if (st_q == S_ENCEV && !full) begin
      mem[wi_q] <= {2'b00, kdee_pkg::LockKey, evk_q};
    end
    rd_q <= mem[ri_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      k_q <= '0;
      raw_q <= '0; stb_q <= '0; ld_q <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        chg_q[i] <= '0; prs_q[i] <= '0; rpt_q[i] <= '0;
      end
      wi_q <= '0; ri_q <= '0;
      encp_q <= '0; steps_q <= '0; net_q <= '0;
      pend_q <= '0; evk_q <= kdee_pkg::KIND_CW;
      event_valid_o <= 1'b0; event_kind_o <= '0; event_key_o <= '0;
      event_amount_o <= '0; encoder_count_o <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            event_valid_o <= 1'b0; event_kind_o <= '0; event_key_o <= '0;
            event_amount_o <= '0;
            encoder_count_o <= (cmd_i.op == kdee_pkg::OP_COUNT) ? net_q : '0;
            k_q <= '0;
            case (cmd_i.op)
              kdee_pkg::OP_TICK: st_q <= S_KEY;
              kdee_pkg::OP_POP:  st_q <= (ri_q != wi_q) ? S_RD : S_DONE;
              kdee_pkg::OP_COUNT: begin
                net_q <= '0;
                st_q <= S_DONE;
              end
              default: begin
                for (int i = 0; i < NUM_KEYS; i++) begin
                  raw_q[i] <= cmd_i.keys[i];
                  stb_q[i] <= cmd_i.keys[i];
                  chg_q[i] <= cmd_i.now;
                  prs_q[i] <= '0; rpt_q[i] <= '0;
                end
                ld_q <= '0;
                wi_q <= '0; ri_q <= '0;
                encp_q <= cmd_i.enc; steps_q <= '0; net_q <= '0;
                st_q <= S_DONE;
              end
            endcase
          end
        end
        S_KEY: begin
          raw_q[k_q] <= rawn;
          chg_q[k_q] <= chgn;
          stb_q[k_q] <= stbn;
          prs_q[k_q] <= prsn;
          ld_q[k_q]  <= ldn;
          if (rep || (fire && rawn)) rpt_q[k_q] <= cmd_i.now;
          pend_q <= pend;
          if (pend != 4'd0) st_q <= S_EV;
          else if (k_q == KW'(NUM_KEYS - 1)) st_q <= S_ENC;
          else k_q <= k_q + 1'b1;
        end
        S_EV: begin
          if (!full) wi_q <= wn;
          pend_q[ev_pick] <= 1'b0;
          if ((pend_q & ~(4'd1 << ev_pick)) == 4'd0) begin
            if (k_q == KW'(NUM_KEYS - 1)) st_q <= S_ENC;
            else begin
              k_q <= k_q + 1'b1;
              st_q <= S_KEY;
            end
          end
        end
        S_ENC: begin
          encp_q <= cmd_i.enc;
          if (sn >= DetentPos) begin
            steps_q <= '0; net_q <= net_q + 16'd1;
            evk_q <= kdee_pkg::KIND_CW; st_q <= S_ENCEV;
          end else if (sn <= DetentNeg) begin
            steps_q <= '0; net_q <= net_q - 16'd1;
            evk_q <= kdee_pkg::KIND_CCW; st_q <= S_ENCEV;
          end else begin
            steps_q <= sn;
            st_q <= S_DONE;
          end
        end
        S_ENCEV: begin
          if (!full) wi_q <= wn;
          st_q <= S_DONE;
        end
        S_RD: begin
          // store data is taken from rd_q, registered from mem[ri_q]
          event_valid_o <= 1'b1;
          event_kind_o <= rd_q[2:0];
          event_key_o <= rd_q[5:3];
          event_amount_o <= (rd_q[2:0] == kdee_pkg::KIND_DOWN ||
                             rd_q[2:0] == kdee_pkg::KIND_UP) ? 2'd0 :
                            (rd_q[2:0] == kdee_pkg::KIND_CCW) ? 2'd3 : 2'd1;
          ri_q <= rn;
          st_q <= S_DONE;
        end
        S_DONE: st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/key_debounce_event_engine_top.sv]
// top level of the key debounce event engine
// usage:
//   - raise start with op_i and the pin/time fields while busy is low;
//     the op is captured as a transfer at that edge and busy rises
//   - done_o strobes for one cycle with every result field valid; the
//     receiver cannot stall, each result is a transfer in that cycle
//   - one result per op; busy drops at the edge that ends the done_o cycle
// sequence in the back end, after the accepting edge:
//   - read-count and initialise: idle straight to done; pop: idle, then a
//     read state when the queue holds an event, then done
//   - tick: the back end walks the keys in turn, pausing to write each
//     pending event into the event store (dropped while full), then steps
//     the encoder, queuing any detent; at most two events per key plus a detent
//   - throughput: the next op is accepted in the cycle after done_o at the earliest
// configuration:
//   - cfg_we_i/cfg_idx_i/cfg_wdata_i write a register at the clock edge;
//     write only while busy is low
// reset:
//   - registers return to defaults (80, 800, 0, 200, active low), key and
//     encoder state clears, queue empties; event store contents undefined
`default_nettype none
module key_debounce_event_engine_top #(
  parameter int NUM_KEYS     = 8,
  parameter int QUEUE_DEPTH  = 32,
  parameter int DETENT_STEPS = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  output logic        done_o,
  input  wire  [1:0]  op_i,
  input  wire  [31:0] now_time_i,
  input  wire  [7:0]  key_pins_i,
  input  wire         enc_a_pin_i,
  input  wire         enc_b_pin_i,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [15:0] cfg_wdata_i,
  output logic        event_valid_o,
  output logic [2:0]  event_kind_o,
  output logic [2:0]  event_key_o,
  output logic [1:0]  event_amount_o,
  output logic [7:0]  pressed_mask_o,
  output logic [15:0] encoder_count_o,
  output logic [4:0]  queue_fill_o
);
  logic [15:0] deb_q, long_q, rst_q, per_q;
  logic        ah_q;
  logic        cmd_valid, cmd_pop;
  kdee_pkg::cmd_t cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= 16'd80; long_q <= 16'd800; rst_q <= 16'd0; per_q <= 16'd200;
      ah_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kdee_pkg::REG_DEBOUNCE:  deb_q  <= cfg_wdata_i;
        kdee_pkg::REG_LONG:      long_q <= cfg_wdata_i;
        kdee_pkg::REG_REP_START: rst_q  <= cfg_wdata_i;
        kdee_pkg::REG_REP_PER:   per_q  <= cfg_wdata_i;
        kdee_pkg::REG_ACT_HIGH:  ah_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  kdee_front #(.NUM_KEYS(NUM_KEYS)) u_front (
    .clk_i, .rst_ni, .start_i(start), .op_i, .now_time_i, .key_pins_i,
    .enc_a_pin_i, .enc_b_pin_i, .active_high_i(ah_q), .pop_i(cmd_pop),
    .busy_o(busy), .cmd_valid_o(cmd_valid), .cmd_o(cmd)
  );

  kdee_back #(
    .NUM_KEYS(NUM_KEYS), .QUEUE_DEPTH(QUEUE_DEPTH), .DETENT_STEPS(DETENT_STEPS)
  ) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .debounce_time_i(deb_q), .long_press_time_i(long_q),
    .repeat_start_time_i(rst_q), .repeat_period_i(per_q),
    .cmd_pop_o(cmd_pop), .done_o, .event_valid_o, .event_kind_o,
    .event_key_o, .event_amount_o, .pressed_mask_o, .encoder_count_o,
    .queue_fill_o
  );
endmodule
`default_nettype wire
